FILE: rtl/bts_pkg.sv
// Package: widths, constants, state and command types of the block transfer sequencer.
package bts_pkg;

	localparam int NUM_REGS = 16;
	localparam int LIST_W   = 16;
	localparam int IDX_W    = 4;
	localparam int ADDR_W   = 32;
	localparam int SCAN_LIM = (NUM_REGS > LIST_W) ? LIST_W : NUM_REGS;
	localparam logic [LIST_W-1:0] LIST_MASK = (SCAN_LIM >= LIST_W) ? {LIST_W{1'b1}} :
		LIST_W'((33'd1 << SCAN_LIM) - 33'd1);
	localparam int PC_REG = 15;
	localparam logic [ADDR_W-1:0] WORD_STEP = ADDR_W'(4);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} bts_state_t;

	typedef struct packed {
		logic capture;
		logic emit;
	} bts_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_now;
	} bts_sts_t;

endpackage

FILE: rtl/bts_ctrl.sv
// Controller: state machine that captures an instruction and paces the transfers.
module bts_ctrl import bts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  bts_sts_t sts,
	output bts_cmd_t cmd
);

	bts_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.out_free && sts.last_now) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_RUN: begin
				cmd.emit = sts.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

FILE: rtl/bts_dp.sv
// Datapath: instruction registers, register picker, address stepper and output register.
module bts_dp import bts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bts_cmd_t          cmd,
	output bts_sts_t          sts,
	input  logic              func,
	input  logic              pre_index,
	input  logic              up,
	input  logic              s_flag,
	input  logic              write_back,
	input  logic [IDX_W-1:0]  base_reg,
	input  logic [LIST_W-1:0] reg_list,
	input  logic [ADDR_W-1:0] base_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              access_valid,
	output logic [ADDR_W-1:0] access_address,
	output logic [IDX_W-1:0]  reg_index,
	output logic              is_load,
	output logic              user_bank,
	output logic              base_update,
	output logic [ADDR_W-1:0] new_base,
	output logic              restore_status,
	output logic              last
);

	logic [LIST_W-1:0] list_q;
	logic [ADDR_W-1:0] addr_q;
	logic              load_q, pre_q, up_q, ubank_q, update_q, restore_q;
	logic              out_valid_q;

	logic [LIST_W-1:0] in_list, rev, iso, rem;
	logic [IDX_W-1:0]  pos, pick;
	logic [ADDR_W-1:0] stepped;
	logic              pc_listed, base_in_list, empty, rem_empty;

	assign in_list      = reg_list & LIST_MASK;
	assign pc_listed    = in_list[PC_REG];
	assign base_in_list = (32'(base_reg) < 32'(SCAN_LIM)) && in_list[base_reg];

	always_comb begin
		for (int i = 0; i < LIST_W; i++) begin
			rev[i] = list_q[LIST_W-1-i];
		end
	end

	assign iso = up_q ? (list_q & (~list_q + LIST_W'(1))) : (rev & (~rev + LIST_W'(1)));

	always_comb begin
		pos = '0;
		for (int i = 0; i < LIST_W; i++) begin
			if (iso[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign pick      = up_q ? pos : (IDX_W'(LIST_W - 1) - pos);
	assign rem       = list_q & ~(LIST_W'(1) << pick);
	assign empty     = (list_q == '0);
	assign rem_empty = (rem == '0);
	assign stepped   = up_q ? (addr_q + WORD_STEP) : (addr_q - WORD_STEP);

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.last_now = empty || rem_empty;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			list_q    <= in_list;
			addr_q    <= base_value;
			load_q    <= func;
			pre_q     <= pre_index;
			up_q      <= up;
			ubank_q   <= func ? (s_flag && !pc_listed) : s_flag;
			update_q  <= write_back && !(func && base_in_list);
			restore_q <= func && s_flag && pc_listed;
		end else if (cmd.emit && !empty) begin
			list_q <= rem;
			addr_q <= stepped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			is_load   <= load_q;
			user_bank <= ubank_q;
			if (empty) begin
				access_valid   <= 1'b0;
				access_address <= '0;
				reg_index      <= '0;
				last           <= 1'b1;
				new_base       <= addr_q;
				base_update    <= update_q;
				restore_status <= restore_q;
			end else begin
				access_valid   <= 1'b1;
				access_address <= pre_q ? stepped : addr_q;
				reg_index      <= pick;
				last           <= rem_empty;
				new_base       <= rem_empty ? stepped : '0;
				base_update    <= rem_empty && update_q;
				restore_status <= rem_empty && restore_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/block_transfer_sequencer_unit.sv
// Top level: block transfer sequencer, controller joined to datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | one load/store-multiple instruction
//  out     | output    | out_valid / out_stall  | one word transfer per listed register
//
//  An instruction is first captured; then the register picker and address stepper give
//  one transfer a cycle unless out_stall holds them; an empty list gives one without access.
//  A new instruction is taken once the last transfer is in the output register.
//  out_stall holds the output register and the sequencer; reset clears state and output valid.
module block_transfer_sequencer_unit import bts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic              pre_index,
	input  logic              up,
	input  logic              s_flag,
	input  logic              write_back,
	input  logic [IDX_W-1:0]  base_reg,
	input  logic [LIST_W-1:0] reg_list,
	input  logic [ADDR_W-1:0] base_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              access_valid,
	output logic [ADDR_W-1:0] access_address,
	output logic [IDX_W-1:0]  reg_index,
	output logic              is_load,
	output logic              user_bank,
	output logic              base_update,
	output logic [ADDR_W-1:0] new_base,
	output logic              restore_status,
	output logic              last
);

	bts_cmd_t cmd;
	bts_sts_t sts;

	bts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (func),
		.pre_index      (pre_index),
		.up             (up),
		.s_flag         (s_flag),
		.write_back     (write_back),
		.base_reg       (base_reg),
		.reg_list       (reg_list),
		.base_value     (base_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.access_valid   (access_valid),
		.access_address (access_address),
		.reg_index      (reg_index),
		.is_load        (is_load),
		.user_bank      (user_bank),
		.base_update    (base_update),
		.new_base       (new_base),
		.restore_status (restore_status),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !access_valid |-> last)
		else $error("transfer without access is not last");

	a_tail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !base_update && !restore_status && new_base == '0)
		else $error("writeback fields set on a transfer that is not last");

	a_restore_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restore_status |-> is_load && !user_bank)
		else $error("status restore on a store or with user bank");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("instruction taken while a previous one is sequencing");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the block transfer sequencer: directed and random LDM/STM traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bts_pkg::*;

	localparam logic OP_STM = 1'b0;
	localparam logic OP_LDM = 1'b1;
	localparam int IDLE_MAX = 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 24;

	typedef struct {
		logic              func;
		logic              pre_index;
		logic              up;
		logic              s_flag;
		logic              write_back;
		logic [IDX_W-1:0]  base_reg;
		logic [LIST_W-1:0] reg_list;
		logic [ADDR_W-1:0] base_value;
	} instr_t;

	typedef struct {
		logic              access_valid;
		logic [ADDR_W-1:0] access_address;
		logic [IDX_W-1:0]  reg_index;
		logic              is_load;
		logic              user_bank;
		logic              base_update;
		logic [ADDR_W-1:0] new_base;
		logic              restore_status;
		logic              last;
	} xfer_t;

	class transfer_book;
		xfer_t due[$];

		function int pending();
			return due.size();
		endfunction

		function void note_instr(instr_t ins);
			logic [LIST_W-1:0] list;
			logic              pc_in;
			logic              ubank;
			logic              restore;
			logic              base_hit;
			logic              upd;
			logic [ADDR_W-1:0] addr;
			xfer_t             tmpl;
			xfer_t             cur;
			bit                held;
			int                r;
			list = ins.reg_list & LIST_MASK;
			pc_in = list[PC_REG];
			ubank = ins.func ? (ins.s_flag & ~pc_in) : ins.s_flag;
			restore = ins.func & ins.s_flag & pc_in;
			base_hit = (int'(ins.base_reg) < SCAN_LIM) && list[ins.base_reg];
			upd = ins.write_back & ~(ins.func & base_hit);
			addr = ins.base_value;
			tmpl = '{default: 0};
			tmpl.is_load = ins.func;
			tmpl.user_bank = ubank;
			cur = tmpl;
			held = 0;
			for (int j = 0; j < SCAN_LIM; j++) begin
				r = ins.up ? j : SCAN_LIM - 1 - j;
				if (list[r]) begin
					if (held)
						due = {due, cur};
					if (ins.pre_index)
						addr = ins.up ? addr + WORD_STEP : addr - WORD_STEP;
					cur = tmpl;
					cur.access_valid = 1'b1;
					cur.access_address = addr;
					cur.reg_index = IDX_W'(r);
					if (!ins.pre_index)
						addr = ins.up ? addr + WORD_STEP : addr - WORD_STEP;
					held = 1;
				end
			end
			if (!held) begin
				cur = tmpl;
				addr = ins.base_value;
			end
			cur.base_update = upd;
			cur.new_base = addr;
			cur.restore_status = restore;
			cur.last = 1'b1;
			due = {due, cur};
		endfunction

		function string check_transfer(xfer_t got);
			xfer_t want;
			string msg;
			if (due.size() == 0)
				return "transfer with no expectation waiting";
			want = due.pop_front();
			msg = "";
			if (got.access_valid !== want.access_valid)
				msg = {msg, $sformatf(" access_valid %0b exp %0b",
					got.access_valid, want.access_valid)};
			if (got.access_address !== want.access_address)
				msg = {msg, $sformatf(" access_address %h exp %h",
					got.access_address, want.access_address)};
			if (got.reg_index !== want.reg_index)
				msg = {msg, $sformatf(" reg_index %0d exp %0d", got.reg_index, want.reg_index)};
			if (got.is_load !== want.is_load)
				msg = {msg, $sformatf(" is_load %0b exp %0b", got.is_load, want.is_load)};
			if (got.user_bank !== want.user_bank)
				msg = {msg, $sformatf(" user_bank %0b exp %0b", got.user_bank, want.user_bank)};
			if (got.base_update !== want.base_update)
				msg = {msg, $sformatf(" base_update %0b exp %0b",
					got.base_update, want.base_update)};
			if (got.new_base !== want.new_base)
				msg = {msg, $sformatf(" new_base %h exp %h", got.new_base, want.new_base)};
			if (got.restore_status !== want.restore_status)
				msg = {msg, $sformatf(" restore_status %0b exp %0b",
					got.restore_status, want.restore_status)};
			if (got.last !== want.last)
				msg = {msg, $sformatf(" last %0b exp %0b", got.last, want.last)};
			return msg;
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              func = 1'b0;
	logic              pre_index = 1'b0;
	logic              up = 1'b0;
	logic              s_flag = 1'b0;
	logic              write_back = 1'b0;
	logic [IDX_W-1:0]  base_reg = '0;
	logic [LIST_W-1:0] reg_list = '0;
	logic [ADDR_W-1:0] base_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              access_valid;
	logic [ADDR_W-1:0] access_address;
	logic [IDX_W-1:0]  reg_index;
	logic              is_load;
	logic              user_bank;
	logic              base_update;
	logic [ADDR_W-1:0] new_base;
	logic              restore_status;
	logic              last;

	transfer_book book = new;
	int errors = 0;
	int quiet_cycles = 0;
	bit tx_idle = 1;
	bit rx_idle = 1;
	bit hold_off_req = 0;

	block_transfer_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.pre_index(pre_index),
		.up(up),
		.s_flag(s_flag),
		.write_back(write_back),
		.base_reg(base_reg),
		.reg_list(reg_list),
		.base_value(base_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.access_valid(access_valid),
		.access_address(access_address),
		.reg_index(reg_index),
		.is_load(is_load),
		.user_bank(user_bank),
		.base_update(base_update),
		.new_base(new_base),
		.restore_status(restore_status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(string what);
		errors++;
		$display("[%0t] mismatch:%s", $time, what);
	endtask

	always @(posedge clk) begin : monitor
		instr_t ins;
		xfer_t  got;
		string  msg;
		if (arst_n && in_valid && !in_stall) begin
			ins = '{func, pre_index, up, s_flag, write_back, base_reg, reg_list, base_value};
			book.note_instr(ins);
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{access_valid, access_address, reg_index, is_load, user_bank,
				base_update, new_base, restore_status, last};
			msg = book.check_transfer(got);
			if (msg != "")
				report(msg);
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				n = HOLD_OFF_CYCLES;
				hold_off_req = 0;
			end else begin
				n = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic instr_t mk(logic f, logic p, logic u, logic s, logic w,
		logic [IDX_W-1:0] b, logic [LIST_W-1:0] l, logic [ADDR_W-1:0] v);
		instr_t ins;
		ins = '{f, p, u, s, w, b, l, v};
		return ins;
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		logic [LIST_W-1:0] a;
		logic [LIST_W-1:0] b;
		a = LIST_W'($urandom);
		b = LIST_W'($urandom);
		ins.func = 1'($urandom_range(0, 1));
		ins.pre_index = 1'($urandom_range(0, 1));
		ins.up = 1'($urandom_range(0, 1));
		ins.s_flag = 1'($urandom_range(0, 1));
		ins.write_back = 1'($urandom_range(0, 1));
		ins.base_reg = IDX_W'($urandom);
		case ($urandom_range(0, 6))
			0: ins.reg_list = a;
			1: ins.reg_list = a & b;
			2: ins.reg_list = a | b;
			3: ins.reg_list = LIST_W'(1) << $urandom_range(0, LIST_W - 1);
			4: ins.reg_list = '0;
			5: ins.reg_list = a | (LIST_W'(1) << ins.base_reg);
			default: ins.reg_list = a & b & LIST_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: ins.base_value = ADDR_W'($urandom_range(0, 64));
			1: ins.base_value = ~ADDR_W'($urandom_range(0, 64));
			default: ins.base_value = ADDR_W'($urandom);
		endcase
		return ins;
	endfunction

	task automatic send_instr(instr_t ins);
		int gap;
		gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= ins.func;
		pre_index <= ins.pre_index;
		up <= ins.up;
		s_flag <= ins.s_flag;
		write_back <= ins.write_back;
		base_reg <= ins.base_reg;
		reg_list <= ins.reg_list;
		base_value <= ins.base_value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_instr(mk(OP_STM, 0, 1, 0, 0, 0, 16'h0000, 32'h0000_1000));
		send_instr(mk(OP_LDM, 1, 0, 1, 1, 3, 16'h0000, 32'h0000_2000));
		send_instr(mk(OP_STM, 0, 1, 0, 1, 13, 16'hFFFF, 32'h0000_8000));
		send_instr(mk(OP_STM, 1, 1, 0, 1, 13, 16'hFFFF, 32'h0000_8000));
		send_instr(mk(OP_LDM, 0, 0, 0, 1, 13, 16'hFFFF, 32'h0000_8000));
		send_instr(mk(OP_LDM, 1, 0, 0, 0, 13, 16'hFFFF, 32'h0000_8000));
		send_instr(mk(OP_STM, 0, 1, 0, 0, 0, 16'h0001, 32'hFFFF_FFFF));
		send_instr(mk(OP_LDM, 1, 1, 0, 1, 15, 16'h8000, 32'hFFFF_FFFC));
		send_instr(mk(OP_STM, 1, 0, 0, 1, 0, 16'h0001, 32'h0000_0000));
		send_instr(mk(OP_LDM, 0, 1, 0, 1, 4, 16'h0010, 32'h0000_0100));
		send_instr(mk(OP_LDM, 0, 1, 0, 1, 5, 16'h0010, 32'h0000_0100));
		send_instr(mk(OP_LDM, 0, 1, 1, 0, 0, 16'h80F0, 32'h0000_0400));
		send_instr(mk(OP_LDM, 1, 0, 1, 1, 2, 16'h00F0, 32'h0000_0400));
		send_instr(mk(OP_STM, 0, 0, 1, 1, 2, 16'h8001, 32'h0000_0008));
		send_instr(mk(OP_STM, 1, 1, 1, 0, 2, 16'h7FFE, 32'hFFFF_FFF0));
		send_instr(mk(OP_LDM, 0, 0, 1, 1, 15, 16'hAAAA, 32'h0000_0004));
		send_instr(mk(OP_STM, 1, 0, 0, 1, 7, 16'h5555, 32'hDEAD_BEEC));
		send_instr(mk(OP_LDM, 1, 1, 1, 1, 0, 16'hFFFF, 32'h0000_0000));

		repeat (40) send_instr(rand_instr());

		hold_off_req = 1;
		tx_idle = 0;
		repeat (12) send_instr(rand_instr());
		wait_drained();

		rx_idle = 0;
		repeat (30) send_instr(rand_instr());

		tx_idle = 1;
		rx_idle = 1;
		repeat (30) send_instr(rand_instr());

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.pending() != 0)
			report($sformatf(" %0d expected transfers never arrived", book.pending()));
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
